[sv/frame_brightness_average_macros.svh]
// Assertion macros for the frame brightness average block.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef FRAME_BRIGHTNESS_AVERAGE_MACROS_SVH
`define FRAME_BRIGHTNESS_AVERAGE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame_brightness_average: check failed");

// Next-cycle implication, checked outside reset.
`define FBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame_brightness_average: check failed");

`endif

[sv/fba_pkg.sv]
// Shared types and constants for the frame brightness average block.
// No dependencies.
package fba_pkg;

  localparam int VAL_W   = 24;  // Q8.16 sample and result width
  localparam int SUM_W   = 40;  // frame sum width
  localparam int CNT_W   = 17;  // pixel count register width
  localparam int SHIFT_W = 4;   // alpha shift register width
  localparam int IDX_W   = 2;   // config register index width

  localparam int QDEPTH  = 4;   // frame sums waiting between front and back
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int MAX_PIXELS_DEF = 65536;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [IDX_W-1:0] REG_CLAMP_LIMIT = 2'd0;
  localparam logic [IDX_W-1:0] REG_PIXEL_COUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_ALPHA_SHIFT = 2'd2;

  localparam logic [CNT_W-1:0]   PIXEL_COUNT_RST = 17'd64;
  localparam logic [SHIFT_W-1:0] ALPHA_SHIFT_RST = 4'd6;

  typedef struct packed {
    logic [VAL_W-1:0]   clamp_limit;
    logic [CNT_W-1:0]   pixel_count;
    logic [SHIFT_W-1:0] alpha_shift;
  } cfg_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  // 64.0 in the chosen fixed-point format, saturated to the sample width
  function automatic logic [VAL_W-1:0] clamp_reset(input int frac);
    longint v;
    v = longint'(64) << frac;
    if (v > ((longint'(1) << VAL_W) - 1))
      return {VAL_W{1'b1}};
    return VAL_W'(v);
  endfunction

endpackage

[sv/fba_front.sv]
// Front part: clamps and accumulates samples, hands each finished frame sum on.
// Depends on fba_pkg.
module fba_front (
  input  logic                       clk,
  input  logic                       rst,
  input  fba_pkg::cfg_t              cfg,
  input  logic                       accept,
  input  logic [fba_pkg::VAL_W-1:0]  sample,
  input  logic                       sample_invalid,
  input  logic                       last_of_frame,
  output logic                       sum_push,
  output logic [fba_pkg::SUM_W-1:0]  sum_data
);

  logic [fba_pkg::SUM_W-1:0] frame_sum;
  logic [fba_pkg::SUM_W-1:0] frame_sum_next;
  logic [fba_pkg::VAL_W-1:0] clamped;
  logic [fba_pkg::SUM_W:0]   wide_sum;
  logic [fba_pkg::SUM_W-1:0] acc;

  always_comb begin
    clamped  = (sample > cfg.clamp_limit) ? cfg.clamp_limit : sample;
    wide_sum = {1'b0, frame_sum} + (fba_pkg::SUM_W + 1)'(clamped);
    // saturate at the top of the sum range
    if (sample_invalid)
      acc = frame_sum;
    else if (wide_sum[fba_pkg::SUM_W])
      acc = {fba_pkg::SUM_W{1'b1}};
    else
      acc = wide_sum[fba_pkg::SUM_W-1:0];

    frame_sum_next = frame_sum;
    if (accept)
      frame_sum_next = last_of_frame ? '0 : acc;
  end

  assign sum_push = accept & last_of_frame;
  assign sum_data = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sum <= '0;
    end else begin
      frame_sum <= frame_sum_next;
    end
  end

endmodule

[sv/fba_queue.sv]
// Short queue of frame sums between the front and the back.
// Depends on fba_pkg.
module fba_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [fba_pkg::SUM_W-1:0]  push_data,
  input  logic                       pop,
  output logic [fba_pkg::SUM_W-1:0]  head,
  output fba_pkg::qstat_t            stat
);

  logic [fba_pkg::SUM_W-1:0]  slots [fba_pkg::QDEPTH];
  logic [fba_pkg::QPTR_W-1:0] wr_ptr;
  logic [fba_pkg::QPTR_W-1:0] rd_ptr;
  logic [fba_pkg::QCNT_W-1:0] count;
  logic                       do_push;
  logic                       do_pop;

  assign stat.count = count;
  assign stat.full  = (count == fba_pkg::QCNT_W'(fba_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push)
      slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)
        count <= count + 1'b1;
      else if (do_pop && !do_push)
        count <= count - 1'b1;
    end
  end

endmodule

[sv/fba_back.sv]
// Back part: divides each frame sum by the pixel count (one quotient bit per
// cycle), updates the moving average and holds the result word. Depends on fba_pkg.
module fba_back #(
  parameter int MAX_PIXELS = fba_pkg::MAX_PIXELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fba_pkg::cfg_t              cfg,
  input  logic                       q_empty,
  input  logic [fba_pkg::SUM_W-1:0]  q_head,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic                       load,
  output logic [fba_pkg::VAL_W-1:0]  frame_mean,
  output logic [fba_pkg::VAL_W-1:0]  running_average
);

  localparam int CNT_W   = fba_pkg::CNT_W;
  localparam int SUM_W   = fba_pkg::SUM_W;
  localparam int VAL_W   = fba_pkg::VAL_W;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] DIV_CAP =
    CNT_W'((MAX_PIXELS > CNT_MAX) ? CNT_MAX : MAX_PIXELS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMA  = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [SUM_W-1:0]  dvd;        // dividend bits shift out, quotient bits shift in
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic [STEP_W-1:0] step;
  logic              res_valid;

  logic [CNT_W-1:0]        div_now;
  logic [CNT_W:0]          trial;
  logic                    qbit;
  logic [VAL_W-1:0]        mean_sat;
  logic signed [VAL_W:0]   diff;
  logic signed [VAL_W:0]   delta;
  logic signed [VAL_W:0]   avg_sum;

  always_comb begin
    if (cfg.pixel_count == '0)
      div_now = CNT_W'(1);
    else if (cfg.pixel_count > DIV_CAP)
      div_now = DIV_CAP;
    else
      div_now = cfg.pixel_count;

    trial = {rem, dvd[SUM_W-1]};
    qbit  = (trial >= {1'b0, divisor});

    mean_sat = (dvd[SUM_W-1:VAL_W] != '0) ? {VAL_W{1'b1}} : dvd[VAL_W-1:0];
    diff     = $signed({1'b0, mean_sat}) - $signed({1'b0, running_average});
    delta    = diff >>> cfg.alpha_shift;
    avg_sum  = $signed({1'b0, running_average}) + delta;
  end

  assign q_pop = (state == S_IDLE) & ~q_empty;
  assign load  = (state == S_EMA) & (~res_valid | pop);
  assign empty = ~res_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (!q_empty) state_next = S_DIV;
      S_DIV:  if (step == STEP_W'(SUM_W - 1)) state_next = S_EMA;
      S_EMA:  if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      res_valid       <= 1'b0;
      running_average <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        res_valid       <= 1'b1;
        running_average <= avg_sum[VAL_W-1:0];
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (q_pop) begin
      dvd     <= q_head;
      rem     <= '0;
      divisor <= div_now;
      step    <= '0;
    end else if (state == S_DIV) begin
      rem  <= qbit ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
      dvd  <= {dvd[SUM_W-2:0], qbit};
      step <= step + 1'b1;
    end
    if (load)
      frame_mean <= mean_sat;
  end

endmodule

[sv/frame_brightness_average.sv]
// Frame brightness average: accumulates clamped Q8.16 brightness samples, and
// at each frame end divides the sum by the pixel count and updates a moving
// average. A sample is taken every cycle; the front only stalls (full high)
// when four finished frame sums already wait for the divider. For each frame
// the back pops a sum, runs the one-bit-per-cycle divider over the whole sum
// width, then loads the result and updates the average, so short frames back
// up once the queue fills. Results leave through a single held word, and the
// back takes no new frame while it waits. No clearing pass after reset.
`include "frame_brightness_average_macros.svh"

module frame_brightness_average #(
  parameter int MAX_PIXELS = fba_pkg::MAX_PIXELS_DEF,
  parameter int FRAC_BITS  = fba_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [fba_pkg::VAL_W-1:0]    sample,
  input  logic                         sample_invalid,
  input  logic                         last_of_frame,
  output logic                         empty,
  input  logic                         pop,
  output logic [fba_pkg::VAL_W-1:0]    frame_mean,
  output logic [fba_pkg::VAL_W-1:0]    running_average,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fba_pkg::IDX_W-1:0]    cfg_index,
  input  logic [fba_pkg::VAL_W-1:0]    cfg_data
);

  localparam logic [fba_pkg::VAL_W-1:0] CLAMP_RST = fba_pkg::clamp_reset(FRAC_BITS);

  fba_pkg::cfg_t             cfg;
  fba_pkg::qstat_t           qstat;
  logic                      accept;
  logic                      sum_push;
  logic [fba_pkg::SUM_W-1:0] sum_data;
  logic [fba_pkg::SUM_W-1:0] q_head;
  logic                      q_pop;
  logic                      load;

  assign cfg_ready = 1'b1;
  assign full      = qstat.full;
  assign accept    = push & ~qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clamp_limit <= CLAMP_RST;
      cfg.pixel_count <= fba_pkg::PIXEL_COUNT_RST;
      cfg.alpha_shift <= fba_pkg::ALPHA_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      // unknown indexes drop the word
      unique case (cfg_index)
        fba_pkg::REG_CLAMP_LIMIT: cfg.clamp_limit <= cfg_data;
        fba_pkg::REG_PIXEL_COUNT: cfg.pixel_count <= cfg_data[fba_pkg::CNT_W-1:0];
        fba_pkg::REG_ALPHA_SHIFT: cfg.alpha_shift <= cfg_data[fba_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  fba_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .sample         (sample),
    .sample_invalid (sample_invalid),
    .last_of_frame  (last_of_frame),
    .sum_push       (sum_push),
    .sum_data       (sum_data)
  );

  fba_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (sum_push),
    .push_data (sum_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (qstat)
  );

  fba_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_empty         (qstat.empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .load            (load),
    .frame_mean      (frame_mean),
    .running_average (running_average)
  );

  `FBA_ASSERT_NOW(a_queue_bound, 1'b1, qstat.count <= fba_pkg::QCNT_W'(fba_pkg::QDEPTH))
  `FBA_ASSERT_NEXT(a_frame_queued, accept && last_of_frame, !qstat.empty)
  `FBA_ASSERT_NEXT(a_pop_drains, pop && !empty && !load, empty)
  `FBA_ASSERT_NEXT(a_load_shows, load, !empty)

endmodule

[tb/fba_result_check.sv]
`timescale 1ns / 1ps
// Result checker for the frame brightness average block: follows the sample,
// result and register channels, predicts each frame result and compares it.
// Depends on fba_pkg for widths and register indexes.
module fba_result_check (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  logic [fba_pkg::VAL_W-1:0] sample,
  input  logic                      sample_invalid,
  input  logic                      last_of_frame,
  input  logic                      empty,
  input  logic                      pop,
  input  logic [fba_pkg::VAL_W-1:0] frame_mean,
  input  logic [fba_pkg::VAL_W-1:0] running_average,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [fba_pkg::IDX_W-1:0] cfg_index,
  input  logic [fba_pkg::VAL_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        outstanding,
  output int                        frames_checked
);
  import fba_pkg::*;

  typedef struct {
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] avg;
  } frame_result_t;

  frame_result_t expected_frames[$];

  logic [VAL_W-1:0]   clamp_r;
  logic [CNT_W-1:0]   count_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [SUM_W-1:0]   sum_acc;
  logic [VAL_W-1:0]   avg_acc;
  int errors = 0;
  int frames_seen = 0;

  function automatic logic [CNT_W-1:0] frame_divisor();
    logic [CNT_W-1:0] d;
    d = count_r;
    if (d == '0)
      d = CNT_W'(1);
    if (d > CNT_W'(MAX_PIXELS_DEF))
      d = CNT_W'(MAX_PIXELS_DEF);
    return d;
  endfunction

  // Step toward the mean; a downward step rounds toward minus infinity.
  function automatic logic [VAL_W-1:0] next_average(input logic [VAL_W-1:0] avg,
                                                    input logic [VAL_W-1:0] mean,
                                                    input logic [SHIFT_W-1:0] sh);
    logic [VAL_W:0] gap;
    logic [VAL_W:0] down;
    if (mean >= avg)
      return avg + ((mean - avg) >> sh);
    gap = {1'b0, avg - mean};
    down = (gap + (({{VAL_W{1'b0}}, 1'b1} << sh) - (VAL_W + 1)'(1))) >> sh;
    return avg - down[VAL_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [SUM_W:0]   wide;
    logic [SUM_W-1:0] quot;
    logic [VAL_W-1:0] clipped;
    logic [VAL_W-1:0] mean;
    frame_result_t    want;
    if (rst) begin
      clamp_r = 24'h400000;
      count_r = PIXEL_COUNT_RST;
      shift_r = ALPHA_SHIFT_RST;
      sum_acc = '0;
      avg_acc = '0;
      expected_frames.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CLAMP_LIMIT: clamp_r = cfg_data;
          REG_PIXEL_COUNT: count_r = cfg_data[CNT_W-1:0];
          REG_ALPHA_SHIFT: shift_r = cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end

      // results first, so a word popped with nothing waiting is never hidden
      if (pop && !empty) begin
        if (expected_frames.size() == 0) begin
          if (errors < 10)
            $display("result check: unexpected word mean %h avg %h",
                     frame_mean, running_average);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          if (frame_mean !== want.mean) begin
            if (errors < 10)
              $display("result check: frame %0d frame_mean expected %h got %h",
                       frames_seen, want.mean, frame_mean);
            errors++;
          end
          if (running_average !== want.avg) begin
            if (errors < 10)
              $display("result check: frame %0d running_average expected %h got %h",
                       frames_seen, want.avg, running_average);
            errors++;
          end
          frames_seen++;
        end
      end

      if (push && !full) begin
        if (!sample_invalid) begin
          clipped = (sample > clamp_r) ? clamp_r : sample;
          wide = {1'b0, sum_acc} + (SUM_W + 1)'(clipped);
          sum_acc = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
        end
        if (last_of_frame) begin
          quot = sum_acc / SUM_W'(frame_divisor());
          mean = (quot > {{(SUM_W-VAL_W){1'b0}}, {VAL_W{1'b1}}}) ? {VAL_W{1'b1}}
                                                                  : quot[VAL_W-1:0];
          avg_acc = next_average(avg_acc, mean, shift_r);
          want.mean = mean;
          want.avg = avg_acc;
          expected_frames.push_back(want);
          sum_acc = '0;
        end
      end
    end
    fail_count <= errors;
    outstanding <= expected_frames.size();
    frames_checked <= frames_seen;
  end

endmodule

[tb/tb_frame_brightness_average.sv]
`timescale 1ns / 1ps
// Testbench top for the frame brightness average block: drives samples,
// register writes and result pops, and gives the verdict.
// Depends on fba_pkg, the block itself and fba_result_check.
module tb_frame_brightness_average;
  import fba_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic sample_invalid = 1'b0;
  logic last_of_frame = 1'b0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [VAL_W-1:0] sample = '0;
  logic [VAL_W-1:0] cfg_data = '0;
  logic [IDX_W-1:0] cfg_index = '0;

  wire full;
  wire empty;
  wire cfg_ready;
  wire [VAL_W-1:0] frame_mean;
  wire [VAL_W-1:0] running_average;

  int fail_count;
  int outstanding;
  int frames_checked;
  int items_sent = 0;
  int reg_writes = 0;
  bit push_gaps = 1'b1;
  bit pop_gaps = 1'b1;
  logic [VAL_W-1:0] cur_clamp = 24'h400000;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  frame_brightness_average dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .sample(sample), .sample_invalid(sample_invalid), .last_of_frame(last_of_frame),
    .empty(empty), .pop(pop),
    .frame_mean(frame_mean), .running_average(running_average),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fba_result_check result_check (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .sample(sample), .sample_invalid(sample_invalid), .last_of_frame(last_of_frame),
    .empty(empty), .pop(pop),
    .frame_mean(frame_mean), .running_average(running_average),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding), .frames_checked(frames_checked)
  );

  // Result side: hold pop high, drop it for random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (pop_gaps && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  initial begin
    #50_000_000;
    $display("timeout: %0d results still outstanding", outstanding);
    $display("FAILURE");
    $finish;
  end

  // Leaves push high; the next word or end_phase takes it over.
  task automatic send_word(input logic [VAL_W-1:0] s, input logic inv, input logic lst);
    if (push_gaps && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    push <= 1'b1;
    sample <= s;
    sample_invalid <= inv;
    last_of_frame <= lst;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic apply_config(input logic [VAL_W-1:0] clamp_word,
                              input logic [VAL_W-1:0] count_word,
                              input logic [VAL_W-1:0] shift_word,
                              input bit junk);
    write_reg(REG_CLAMP_LIMIT, clamp_word);
    write_reg(REG_PIXEL_COUNT, count_word);
    write_reg(REG_ALPHA_SHIFT, shift_word);
    if (junk)
      write_reg(REG_UNUSED, VAL_W'($urandom()));
    cfg_valid <= 1'b0;
    cur_clamp = clamp_word;
  endtask

  // Hold off the sender until every frame result is back, then let the back settle.
  task automatic end_phase();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_sample();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = cur_clamp + VAL_W'($urandom_range(0, 2)) - VAL_W'(1);
      3: v = VAL_W'($urandom()) >> $urandom_range(0, 20);
      default: v = VAL_W'($urandom());
    endcase
    return v;
  endfunction

  task automatic send_frame(input int len, input bit all_invalid);
    for (int k = 0; k < len; k++)
      send_word(pick_sample(), all_invalid || ($urandom_range(0, 7) == 0), k == len - 1);
  endtask

  initial begin : stimulus
    logic [VAL_W-1:0] clamp_word;
    logic [VAL_W-1:0] count_word;
    int budget;
    int len;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: clamp at 64.0, an invalid last word, an empty frame.
    send_word(24'hFFFFFF, 1'b0, 1'b0);
    send_word(24'h000000, 1'b0, 1'b0);
    send_word(24'h5A5A5A, 1'b1, 1'b0);
    send_word(24'h400000, 1'b0, 1'b1);
    send_word(24'h123456, 1'b0, 1'b0);
    send_word(24'hFFFFFF, 1'b1, 1'b1);
    send_word(24'h000000, 1'b1, 1'b1);
    send_word(24'hFFFFFF, 1'b0, 1'b1);
    end_phase();

    // Divide by one overflows the mean; zero shift copies the mean.
    apply_config(24'hFFFFFF, 24'h000001, 24'hFFFFF0, 1'b0);
    send_word(24'hFFFFFF, 1'b0, 1'b0);
    send_word(24'hFFFFFF, 1'b0, 1'b1);
    send_word(24'h000001, 1'b0, 1'b1);
    end_phase();

    // Zero clamp, zero pixel count, widest shift, write to an unknown index.
    apply_config(24'h000000, 24'hFE0000, 24'h00000F, 1'b1);
    send_word(24'hFFFFFF, 1'b0, 1'b0);
    send_word(24'h800000, 1'b0, 1'b1);
    send_word(24'h000000, 1'b0, 1'b1);
    end_phase();

    // Pixel count above the maximum saturates the divisor.
    apply_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    repeat (3) send_word(24'hFFFFFF, 1'b0, 1'b0);
    send_word(24'hFFFFFF, 1'b0, 1'b1);
    end_phase();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 7))
        0: clamp_word = '0;
        1, 2: clamp_word = '1;
        3: clamp_word = 24'h400000;
        default: clamp_word = VAL_W'($urandom());
      endcase
      case ($urandom_range(0, 7))
        0: count_word = '0;
        1: count_word = 24'h000001;
        2: count_word = 24'h010000;
        3: count_word = VAL_W'($urandom());
        default: count_word = VAL_W'($urandom_range(1, 32));
      endcase
      apply_config(clamp_word, count_word, VAL_W'($urandom()), $urandom_range(0, 3) == 0);
      if (ph == 7) begin
        push_gaps = 1'b0;
        pop_gaps = 1'b0;
      end
      budget = 42;
      while (budget > 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
        send_frame(len, $urandom_range(0, 7) == 0);
        budget -= len;
      end
      end_phase();
    end

    $display("Checked %0d frame results from %0d sample words and %0d register writes.",
             frames_checked, items_sent, reg_writes);
    $display("Run covered directed extremes and 8 random register settings.");
    if (fail_count == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
